FILE: rtl/core/mssd_pkg.sv
// Shared types, command codes and segment fonts for the multiplexed
// seven-segment display driver. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mssd_pkg;

    // Command codes carried in the command field of an input transaction.
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_SHOW_NUM   = 3'd1;
    localparam logic [2:0] CMD_SHOW_TEXT  = 3'd2;
    localparam logic [2:0] CMD_SET_IND    = 3'd3;
    localparam logic [2:0] CMD_BLINK      = 3'd4;
    localparam logic [2:0] CMD_REFRESH    = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_CLEAR_TIMEOUT = 1'b0;
    localparam logic CFG_BLINK_PERIOD  = 1'b1;

    localparam logic [15:0] CLEAR_TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] BLINK_PERIOD_RESET  = 16'd200;

    // Frame word reset values: digit cathode selects in the upper nibble.
    localparam logic [15:0] FRAME0_RESET = 16'b0011000000000000;
    localparam logic [15:0] FRAME1_RESET = 16'b0101000000000000;
    localparam logic [15:0] FRAME2_RESET = 16'b0110000000000000;
    localparam logic [15:0] FRAME3_RESET = 16'h0000;

    // Largest value that three digits can show.
    localparam logic [9:0] NUMBER_MAX = 10'd999;

    // Segment patterns for the decimal digits, segment A in bit 6.
    localparam logic [6:0] DIGIT_FONT [0:9] = '{
        7'b1111110, 7'h30, 7'h6D, 7'h79, 7'h33,
        7'h5B, 7'h5F, 7'h70, 7'h7F, 7'b1111011
    };

    typedef struct packed {
        logic [2:0] command;
        logic [9:0] number;
        logic [7:0] char_left;
        logic [7:0] char_middle;
        logic [7:0] char_right;
        logic [7:0] indicator_bits;
        logic [1:0] blink_slot;
    } in_item_t;

    typedef struct packed {
        logic [15:0] frame_word;
        logic [1:0]  frame_slot;
    } out_item_t;

    // Segment patterns for the three digit positions, left to right.
    typedef struct packed {
        logic [6:0] seg_left;
        logic [6:0] seg_middle;
        logic [6:0] seg_right;
    } seg_set_t;

    // Character font; characters that are not listed come out blank.
    function automatic logic [6:0] char_font(input logic [7:0] ch);
        logic [7:0] offset;
        logic [6:0] pattern;
        offset  = ch - 8'h30;
        pattern = 7'h00;
        case (ch) inside
            "A", "a":       pattern = 7'b1110111;
            "b":            pattern = 7'b0011111;
            "C":            pattern = 7'h4E;
            "c":            pattern = 7'h0D;
            "d":            pattern = 7'h3D;
            "E", "e":       pattern = 7'h4F;
            "F", "f":       pattern = 7'h47;
            "H":            pattern = 7'h37;
            "h":            pattern = 7'h17;
            "I", "l":       pattern = 7'h30;
            "i":            pattern = 7'h10;
            "J", "j":       pattern = 7'h3C;
            "L":            pattern = 7'h0E;
            "N":            pattern = 7'h76;
            "n":            pattern = 7'h15;
            "O":            pattern = 7'h7E;
            "o":            pattern = 7'h1D;
            "P", "p":       pattern = 7'h67;
            "q":            pattern = 7'h73;
            "r":            pattern = 7'h05;
            "S", "s":       pattern = 7'h5B;
            "t":            pattern = 7'h0F;
            "U":            pattern = 7'h3E;
            "u":            pattern = 7'h1C;
            "Y", "y":       pattern = 7'h3B;
            "-":            pattern = 7'h01;
            "_":            pattern = 7'h08;
            "[":            pattern = 7'h42;
            "]":            pattern = 7'h18;
            [8'h30:8'h39]:  pattern = DIGIT_FONT[offset[3:0]];
            default:        pattern = 7'h00;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mssd_seg_encode.sv
// Segment encoder: turns a show-number or show-text transaction into the
// three digit patterns. Depends on mssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mssd_seg_encode (
    input  wire  mssd_pkg::in_item_t item,
    output mssd_pkg::seg_set_t       segs
);
    import mssd_pkg::*;

    logic [9:0]  value;
    logic [15:0] hund_prod;
    logic [3:0]  hundreds;
    logic [9:0]  hund_weight;
    logic [9:0]  rem_wide;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_weight;
    logic [6:0]  units_wide;
    logic [3:0]  units;

    // Saturate, then split into digits by reciprocal multiplication.
    // v/100 = (v*41)>>12 holds for v below 1000, r/10 = (r*205)>>11 for r below 100.
    always_comb
    begin
        value       = (item.number > NUMBER_MAX) ? NUMBER_MAX : item.number;
        hund_prod   = {6'd0, value} * 16'd41;
        hundreds    = hund_prod[15:12];
        hund_weight = {6'd0, hundreds} * 10'd100;
        rem_wide    = value - hund_weight;
        rem         = rem_wide[6:0];
        tens_prod   = {8'd0, rem} * 15'd205;
        tens        = tens_prod[14:11];
        tens_weight = {3'd0, tens} * 7'd10;
        units_wide  = rem - tens_weight;
        units       = units_wide[3:0];
    end

    // Numbers blank leading zeros; text goes through the character font.
    always_comb
    begin
        if (item.command == CMD_SHOW_NUM)
        begin
            segs.seg_left   = (hundreds == 4'd0) ? 7'h00 : DIGIT_FONT[hundreds];
            segs.seg_middle = (hundreds == 4'd0 && tens == 4'd0) ? 7'h00
                                                                 : DIGIT_FONT[tens];
            segs.seg_right  = DIGIT_FONT[units];
        end
        else
        begin
            segs.seg_left   = char_font(item.char_left);
            segs.seg_middle = char_font(item.char_middle);
            segs.seg_right  = char_font(item.char_right);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/multiplexed_seven_segment_driver.sv
// Top level of the multiplexed seven-segment display driver: input register,
// command execution on the frame words and timers, output register.
// Depends on mssd_pkg and mssd_seg_encode.
// A refresh transaction is executed from the input register, and its frame word
// is registered in the output register.
// Throughput: one transaction per cycle; a refresh waits only while the output
// register holds an untaken result that is stalled.
// Reset: asynchronous, clears the frame words to the cathode select pattern,
// the millisecond timers, blink phase and refresh slot, and loads the default
// clear timeout (3000 ms) and blink period (200 ms).
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_seven_segment_driver (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire  mssd_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output mssd_pkg::out_item_t    out_data,
    input  wire                    cfg_we,
    input  wire                    cfg_index,
    input  wire  [15:0]            cfg_data
);
    import mssd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    in_item_t    in_data_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg;
    logic [15:0] frame_reg [0:3];
    logic [15:0] frame_next [0:3];
    logic [31:0] now_reg, now_next;
    logic [31:0] shown_at_reg, shown_at_next;
    logic [31:0] blink_at_reg, blink_at_next;
    logic        blink_phase_reg, blink_phase_next;
    logic [1:0]  refresh_slot_reg, refresh_slot_next;
    logic [15:0] clear_timeout_reg;
    logic [15:0] blink_period_reg;

    logic        in_accept;
    logic        exec_go;
    logic        exec_refresh;
    logic [31:0] shown_elapsed;
    logic [31:0] blink_elapsed;
    logic        timeout_hit;
    logic        blink_due;
    seg_set_t    segs;

    mssd_seg_encode u_seg_encode (
        .item (in_data_reg),
        .segs (segs)
    );

    // A refresh needs room in the output register; other commands always run.
    assign exec_go      = in_valid_reg &&
                          (in_data_reg.command != CMD_REFRESH || !out_valid_reg || !out_stall);
    assign exec_refresh = exec_go && in_data_reg.command == CMD_REFRESH;
    assign in_stall     = in_valid_reg && !exec_go;
    assign in_accept    = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    // Elapsed times wrap modulo 2^32 and compare strictly greater.
    assign shown_elapsed = now_reg - shown_at_reg;
    assign blink_elapsed = now_reg - blink_at_reg;
    assign timeout_hit   = shown_elapsed > {16'd0, clear_timeout_reg};
    assign blink_due     = blink_elapsed > {16'd0, blink_period_reg};

    // Input register holds one transaction until it executes.
    assign in_valid_next = in_accept ? 1'b1 : (exec_go ? 1'b0 : in_valid_reg);

    // Output register keeps a result until the far side takes it.
    assign out_valid_next = exec_refresh ? 1'b1
                          : ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);

    // Command execution on the frame words and timers.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            frame_next[k] = frame_reg[k];
        end
        now_next          = now_reg;
        shown_at_next     = shown_at_reg;
        blink_at_next     = blink_at_reg;
        blink_phase_next  = blink_phase_reg;
        refresh_slot_next = refresh_slot_reg;

        if (exec_go)
        begin
            case (in_data_reg.command) inside
                CMD_TICK:
                begin
                    now_next = now_reg + 32'd1;
                end
                CMD_SHOW_NUM, CMD_SHOW_TEXT:
                begin
                    frame_next[0][10:4] = segs.seg_left;
                    frame_next[1][10:4] = segs.seg_middle;
                    frame_next[2][10:4] = segs.seg_right;
                    shown_at_next       = now_reg;
                end
                CMD_SET_IND:
                begin
                    frame_next[0][11]  = in_data_reg.indicator_bits[0];
                    frame_next[1][11]  = in_data_reg.indicator_bits[1];
                    frame_next[2][11]  = in_data_reg.indicator_bits[2];
                    frame_next[3][15]  = in_data_reg.indicator_bits[3];
                    frame_next[3][3]   = in_data_reg.indicator_bits[4];
                    frame_next[3][2]   = in_data_reg.indicator_bits[5];
                    frame_next[3][1]   = in_data_reg.indicator_bits[6];
                    frame_next[3][0]   = in_data_reg.indicator_bits[7];
                end
                CMD_BLINK:
                begin
                    if (blink_due)
                    begin
                        blink_phase_next = ~blink_phase_reg;
                        frame_next[in_data_reg.blink_slot][11] = ~blink_phase_reg;
                        blink_at_next    = now_reg;
                    end
                end
                CMD_REFRESH:
                begin
                    refresh_slot_next = refresh_slot_reg + 2'd1;
                    // The word goes out first; the segments blank afterwards.
                    if (timeout_hit)
                    begin
                        frame_next[0][10:4] = 7'h00;
                        frame_next[1][10:4] = 7'h00;
                        frame_next[2][10:4] = 7'h00;
                    end
                end
                default:
                begin
                    // Unused codes leave everything as it is.
                end
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            frame_reg[0]      <= FRAME0_RESET;
            frame_reg[1]      <= FRAME1_RESET;
            frame_reg[2]      <= FRAME2_RESET;
            frame_reg[3]      <= FRAME3_RESET;
            now_reg           <= 32'd0;
            shown_at_reg      <= 32'd0;
            blink_at_reg      <= 32'd0;
            blink_phase_reg   <= 1'b0;
            refresh_slot_reg  <= 2'd0;
            clear_timeout_reg <= CLEAR_TIMEOUT_RESET;
            blink_period_reg  <= BLINK_PERIOD_RESET;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            for (int k = 0; k < 4; k++)
            begin
                frame_reg[k] <= frame_next[k];
            end
            now_reg          <= now_next;
            shown_at_reg     <= shown_at_next;
            blink_at_reg     <= blink_at_next;
            blink_phase_reg  <= blink_phase_next;
            refresh_slot_reg <= refresh_slot_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_CLEAR_TIMEOUT)
                begin
                    clear_timeout_reg <= cfg_data;
                end
                else
                begin
                    blink_period_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= in_data;
        end
        if (exec_refresh)
        begin
            out_data_reg.frame_word <= frame_reg[refresh_slot_reg];
            out_data_reg.frame_slot <= refresh_slot_reg;
        end
    end

    // A refresh advances the rotation by exactly one slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_refresh |=> refresh_slot_reg == $past(refresh_slot_reg) + 2'd1)
    else $error("refresh slot did not advance by one");

    // An executed refresh shows up on the output with the slot it read.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_refresh |=> out_valid_reg && out_data_reg.frame_slot == $past(refresh_slot_reg))
    else $error("refresh result missing or carries the wrong slot");

    // Word three never carries segments or cathode selects.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg[3][14:12] == 3'd0 && frame_reg[3][10:4] == 7'd0)
    else $error("frame word three has stray bits set");

endmodule

`default_nettype wire
